// File: hw/rtl/ffsa_pkg.sv
package ffsa_pkg;

    localparam int CMD_BITS    = 2;
    localparam int REQ_BITS    = 17;
    localparam int OFF_BITS    = 16;
    localparam int STATUS_BITS = 3;
    localparam int ALIGN_BITS  = 13;
    localparam int IN_TAG_BITS  = 8;
    localparam int IN_USER_BITS = 32;
    localparam logic [REQ_BITS-1:0] SPACE_MAX = 17'd65536;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    localparam int REG_TOTAL_SPACE = 0;
    localparam int REG_ALIGN_UNIT  = 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUND,
        S_TAGSCAN,
        S_FITSCAN,
        S_SPLIT,
        S_SHIFT_UP,
        S_FREE_RD,
        S_FREE_NEXT,
        S_FREE_PREV,
        S_SHIFT_DN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic [REQ_BITS-1:0] value;
        logic [ALIGN_BITS-1:0] unit;
    } round_req_t;

    typedef struct packed {
        logic done;
        logic [REQ_BITS:0] value;
    } round_rsp_t;

endpackage

// File: hw/rtl/first_fit_segment_allocator.sv
// First-fit segment allocator.
// Input channel (valid/ready): command, tag, request_size, user_word.
// Output channel (valid/ready): status, seg_offset_out, seg_size_out,
// user_word_out, used_space_out; exactly one result item per input item.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 writes total_space and
// resets the table to one free segment, index 1 writes align_unit.
// One item is worked by a sequencer that walks the segment table one entry
// per cycle; an allocate first rounds its request up to align_unit. in_ready
// is high only while the sequencer is idle, so a new item is not taken
// before the last one has left the sequencer.
// The result sits in an output register, so the next item can be taken and
// worked while it waits; a stalled receiver holds the sequencer in its last
// step until the waiting result is taken.
// Reset: table holds one free segment of 65536 units, align_unit zero.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 32,
    parameter int TAG_BITS     = 8,
    parameter int USER_BITS    = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ffsa_pkg::CMD_BITS-1:0]  command,
    input  logic [ffsa_pkg::IN_TAG_BITS-1:0] tag,
    input  logic [ffsa_pkg::REQ_BITS-1:0]  request_size,
    input  logic [ffsa_pkg::IN_USER_BITS-1:0] user_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ffsa_pkg::STATUS_BITS-1:0] status,
    output logic [ffsa_pkg::OFF_BITS-1:0]  seg_offset_out,
    output logic [ffsa_pkg::REQ_BITS-1:0]  seg_size_out,
    output logic [ffsa_pkg::IN_USER_BITS-1:0] user_word_out,
    output logic [ffsa_pkg::REQ_BITS-1:0]  used_space_out,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [ffsa_pkg::REQ_BITS-1:0]  cfg_data
);
    import ffsa_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_SEGMENTS);

    // segment table
    logic [OFF_BITS-1:0]  start_mem [MAX_SEGMENTS];
    logic [REQ_BITS-1:0]  len_mem   [MAX_SEGMENTS];
    logic                 busy_mem  [MAX_SEGMENTS];
    logic [TAG_BITS-1:0]  tag_mem   [MAX_SEGMENTS];
    logic [USER_BITS-1:0] user_mem  [MAX_SEGMENTS];

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [REQ_BITS-1:0]  used_reg, used_next;
    logic [ALIGN_BITS-1:0] align_reg;
    logic [CNT_BITS-1:0]  ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]  hit_reg, hit_next;
    logic [CMD_BITS-1:0]  cmd_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [REQ_BITS-1:0]  req_reg;
    logic [USER_BITS-1:0] uw_reg;
    logic [REQ_BITS-1:0]  need_reg, need_next;
    logic                 ov_reg, ov_next;
    logic                 ovalid_reg, ovalid_next;
    logic [STATUS_BITS-1:0] st_reg, st_next;
    logic [OFF_BITS-1:0]  off_reg, off_next;
    logic [REQ_BITS-1:0]  size_reg, size_next;
    logic [USER_BITS-1:0] uo_reg, uo_next;

    // output register
    logic                   res_load;
    logic [STATUS_BITS-1:0] out_st_reg;
    logic [OFF_BITS-1:0]    out_off_reg;
    logic [REQ_BITS-1:0]    out_size_reg;
    logic [USER_BITS-1:0]   out_uo_reg;
    logic [REQ_BITS-1:0]    out_used_reg;

    round_req_t rreq;
    round_rsp_t rrsp;

    ffsa_round u_round (
        .clk (clk),
        .rst_n (rst_n),
        .req (rreq),
        .rsp (rrsp)
    );

    logic [IDX_BITS-1:0] p_idx, h_idx, h1_idx, pm1_idx;
    assign p_idx   = ptr_reg[IDX_BITS-1:0];
    assign h_idx   = hit_reg[IDX_BITS-1:0];
    assign h1_idx  = IDX_BITS'(hit_reg + 1'b1);
    assign pm1_idx = IDX_BITS'(ptr_reg - 1'b1);

    // table write command from the sequencer
    typedef enum logic [2:0] {W_NONE, W_COPY_UP, W_SPLIT, W_FREE, W_MERGE_N, W_MERGE_P,
                              W_COPY_DN} wop_t;
    wop_t wop;

    logic in_acc;
    assign in_acc   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    logic [REQ_BITS-1:0] cfg_total;
    always_comb
    begin
        cfg_total = cfg_data;
        if (cfg_data == '0)
            cfg_total = REQ_BITS'(1);
        else if (cfg_data > SPACE_MAX)
            cfg_total = SPACE_MAX;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        used_next   = used_reg;
        ptr_next    = ptr_reg;
        hit_next    = hit_reg;
        need_next   = need_reg;
        ov_next     = ov_reg;
        ovalid_next = ovalid_reg;
        st_next     = st_reg;
        off_next    = off_reg;
        size_next   = size_reg;
        uo_next     = uo_reg;
        wop         = W_NONE;
        res_load    = 1'b0;
        rreq.start  = 1'b0;
        rreq.value  = (req_reg == '0) ? REQ_BITS'(1) : req_reg;
        rreq.unit   = align_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ptr_next = '0;
                    if (command == CMD_ALLOC)
                        state_next = S_ROUND;
                    else if (command == CMD_NONE)
                    begin
                        st_next    = ST_UNKNOWN;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_TAGSCAN;
                end
            end
            S_ROUND:
            begin
                // first cycle starts the rounding unit, ov_reg marks started
                if (!ov_reg)
                begin
                    rreq.start = 1'b1;
                    ov_next    = 1'b1;
                end
                else if (rrsp.done)
                begin
                    ov_next    = 1'b0;
                    if (rrsp.value > {1'b0, SPACE_MAX})
                        need_next = '1;
                    else
                        need_next = rrsp.value[REQ_BITS-1:0];
                    // remember oversize: exceeds any segment
                    hit_next   = (rrsp.value > {1'b0, SPACE_MAX}) ? '1 : '0;
                    state_next = S_TAGSCAN;
                end
            end
            S_TAGSCAN:
            begin
                if (ptr_reg == count_reg)
                begin
                    ptr_next = '0;
                    if (cmd_reg == CMD_ALLOC)
                        state_next = (hit_reg != '0) ? S_DONE : S_FITSCAN;
                    if (cmd_reg == CMD_ALLOC)
                        st_next = ST_NOFIT;
                    else
                    begin
                        st_next    = ST_UNKNOWN;
                        state_next = S_DONE;
                    end
                end
                else if (busy_mem[p_idx] && tag_mem[p_idx] == tag_reg)
                begin
                    hit_next = ptr_reg;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        st_next    = ST_EXISTS;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next   = ST_OK;
                        off_next  = start_mem[p_idx];
                        size_next = len_mem[p_idx];
                        uo_next   = user_mem[p_idx];
                        state_next = (cmd_reg == CMD_FREE) ? S_FREE_RD : S_DONE;
                    end
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_FITSCAN:
            begin
                if (ptr_reg == count_reg)
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_DONE;
                end
                else if (!busy_mem[p_idx] && len_mem[p_idx] >= need_reg)
                begin
                    hit_next = ptr_reg;
                    if (len_mem[p_idx] != need_reg && count_reg >= CNT_MAX)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next   = ST_OK;
                        off_next  = start_mem[p_idx];
                        size_next = need_reg;
                        uo_next   = '0;
                        used_next = used_reg + need_reg;
                        if (len_mem[p_idx] != need_reg)
                        begin
                            ptr_next   = count_reg;
                            state_next = S_SHIFT_UP;
                        end
                        else
                        begin
                            wop        = W_FREE;
                            state_next = S_DONE;
                        end
                    end
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_SHIFT_UP:
            begin
                if (ptr_reg > hit_reg + 1'b1)
                begin
                    wop      = W_COPY_UP;
                    ptr_next = ptr_reg - 1'b1;
                end
                else
                    state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                wop        = W_SPLIT;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_FREE_RD:
            begin
                wop        = W_FREE;
                used_next  = used_reg - size_reg;
                state_next = S_FREE_NEXT;
            end
            S_FREE_NEXT:
            begin
                if (hit_reg + 1'b1 < count_reg && !busy_mem[h1_idx])
                begin
                    wop        = W_MERGE_N;
                    ptr_next   = hit_reg + 2'd2;
                    ov_next    = 1'b1;
                    state_next = S_SHIFT_DN;
                end
                else
                    state_next = S_FREE_PREV;
            end
            S_FREE_PREV:
            begin
                if (hit_reg != '0 && !busy_mem[IDX_BITS'(hit_reg - 1'b1)])
                begin
                    wop        = W_MERGE_P;
                    ptr_next   = hit_reg + 1'b1;
                    ov_next    = 1'b0;
                    state_next = S_SHIFT_DN;
                end
                else
                    state_next = S_DONE;
            end
            S_SHIFT_DN:
            begin
                if (ptr_reg < count_reg)
                begin
                    wop      = W_COPY_DN;
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    ov_next    = 1'b0;
                    state_next = ov_reg ? S_FREE_PREV : S_DONE;
                end
            end
            S_DONE:
            begin
                // wait here while an earlier result is still held
                if (!ovalid_reg || out_ready)
                begin
                    res_load    = 1'b1;
                    ovalid_next = 1'b1;
                    hit_next    = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
                busy_mem[i] <= 1'b0;
            start_mem[0] <= '0;
            len_mem[0]   <= SPACE_MAX;
        end
        else
        begin
            case (wop)
                W_COPY_UP:
                begin
                    start_mem[p_idx] <= start_mem[pm1_idx];
                    len_mem[p_idx]   <= len_mem[pm1_idx];
                    busy_mem[p_idx]  <= busy_mem[pm1_idx];
                    tag_mem[p_idx]   <= tag_mem[pm1_idx];
                    user_mem[p_idx]  <= user_mem[pm1_idx];
                end
                W_SPLIT:
                begin
                    start_mem[h1_idx] <= start_mem[h_idx] + OFF_BITS'(need_reg);
                    len_mem[h1_idx]   <= len_mem[h_idx] - need_reg;
                    busy_mem[h1_idx]  <= 1'b0;
                    len_mem[h_idx]    <= need_reg;
                    busy_mem[h_idx]   <= 1'b1;
                    tag_mem[h_idx]    <= tag_reg;
                    user_mem[h_idx]   <= uw_reg;
                end
                W_FREE:
                begin
                    if (state_reg == S_FITSCAN)
                    begin
                        busy_mem[p_idx] <= 1'b1;
                        tag_mem[p_idx]  <= tag_reg;
                        user_mem[p_idx] <= uw_reg;
                    end
                    else
                        busy_mem[h_idx] <= 1'b0;
                end
                W_MERGE_N:
                    len_mem[h_idx] <= len_mem[h_idx] + len_mem[h1_idx];
                W_MERGE_P:
                    len_mem[IDX_BITS'(hit_reg - 1'b1)] <=
                        len_mem[IDX_BITS'(hit_reg - 1'b1)] + len_mem[h_idx];
                W_COPY_DN:
                begin
                    start_mem[pm1_idx] <= start_mem[p_idx];
                    len_mem[pm1_idx]   <= len_mem[p_idx];
                    busy_mem[pm1_idx]  <= busy_mem[p_idx];
                    tag_mem[pm1_idx]   <= tag_mem[p_idx];
                    user_mem[pm1_idx]  <= user_mem[p_idx];
                end
                default:
                begin
                end
            endcase
            if (cfg_we && cfg_index == 1'(REG_TOTAL_SPACE))
            begin
                start_mem[0] <= '0;
                len_mem[0]   <= cfg_total;
                busy_mem[0]  <= 1'b0;
            end
            if (in_acc)
            begin
                tag_reg <= TAG_BITS'(tag);
                req_reg <= request_size;
                uw_reg  <= USER_BITS'(user_word);
            end
            if (res_load)
            begin
                out_st_reg   <= st_reg;
                out_off_reg  <= (st_reg == ST_OK) ? off_reg : '0;
                out_size_reg <= (st_reg == ST_OK) ? size_reg : '0;
                out_uo_reg   <= (st_reg == ST_OK) ? uo_reg : '0;
                out_used_reg <= used_reg;
            end
            need_reg <= need_next;
            off_reg  <= off_next;
            size_reg <= size_next;
            uo_reg   <= uo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= CNT_BITS'(1);
            used_reg   <= '0;
            align_reg  <= '0;
            ptr_reg    <= '0;
            hit_reg    <= '0;
            cmd_reg    <= CMD_ALLOC;
            ov_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            st_reg     <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            used_reg   <= used_next;
            ptr_reg    <= ptr_next;
            hit_reg    <= hit_next;
            ov_reg     <= ov_next;
            ovalid_reg <= ovalid_next;
            st_reg     <= st_next;
            if (in_acc)
                cmd_reg <= command;
            if (cfg_we && cfg_index == 1'(REG_TOTAL_SPACE))
            begin
                count_reg <= CNT_BITS'(1);
                used_reg  <= '0;
            end
            else if (cfg_we)
                align_reg <= cfg_data[ALIGN_BITS-1:0];
        end
    end

    assign out_valid      = ovalid_reg;
    assign status         = out_st_reg;
    assign seg_offset_out = out_off_reg;
    assign seg_size_out   = out_size_reg;
    assign user_word_out  = IN_USER_BITS'(out_uo_reg);
    assign used_space_out = out_used_reg;

endmodule

// File: hw/rtl/ffsa_round.sv
module ffsa_round (
    input  logic                clk,
    input  logic                rst_n,
    input  ffsa_pkg::round_req_t req,
    output ffsa_pkg::round_rsp_t rsp
);
    import ffsa_pkg::*;

    // Rounds value up to a multiple of unit by repeated addition; zero unit passes it.
    logic [REQ_BITS:0] acc_reg, acc_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            if (req.unit == '0)
            begin
                acc_next  = {1'b0, req.value};
                done_next = 1'b1;
            end
            else
            begin
                acc_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (acc_reg >= {1'b0, req.value})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + {{(REQ_BITS+1-ALIGN_BITS){1'b0}}, req.unit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffsa_pkg::*;

    localparam int SLOTS       = 32;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        status_t      st;
        logic [15:0]  off;
        logic [16:0]  size;
        logic [31:0]  word;
        logic [16:0]  used;
    } seg_result_t;

    typedef struct {
        cmd_t         cmd;
        logic [7:0]   tag;
        logic [16:0]  req;
        logic [31:0]  word;
        seg_result_t  res;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [1:0]   command;
    logic [7:0]   tag;
    logic [16:0]  request_size;
    logic [31:0]  user_word;
    logic         out_valid;
    logic         out_ready;
    logic [2:0]   status;
    logic [15:0]  seg_offset_out;
    logic [16:0]  seg_size_out;
    logic [31:0]  user_word_out;
    logic [16:0]  used_space_out;
    logic         cfg_we;
    logic         cfg_index;
    logic [16:0]  cfg_data;

    first_fit_segment_allocator u_top (.*);

    // predicted table
    int unsigned  seg_base [SLOTS];
    int unsigned  seg_len [SLOTS];
    bit           seg_taken [SLOTS];
    logic [7:0]   seg_owner [SLOTS];
    logic [31:0]  seg_word [SLOTS];
    int           seg_n;
    int unsigned  used_units;
    int unsigned  space_units;
    int unsigned  granule;

    seg_result_t  pending_results [$];
    int           accepted;
    int           errors = 0;
    int           stall = 0;
    int           hold_req;
    dir_row_t     rows [14];

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void clear_segments();
        for (int i = 0; i < SLOTS; i++)
        begin
            seg_base[i] = 0;
            seg_len[i] = 0;
            seg_taken[i] = 0;
            seg_owner[i] = '0;
            seg_word[i] = '0;
        end
        seg_len[0] = space_units;
        seg_n = 1;
        used_units = 0;
    endfunction

    function automatic int owner_of(logic [7:0] t);
        for (int i = 0; i < seg_n; i++)
            if (seg_taken[i] && seg_owner[i] == t)
                return i;
        return -1;
    endfunction

    function automatic void drop_segment(int idx);
        for (int i = idx; i + 1 < seg_n; i++)
        begin
            seg_base[i] = seg_base[i+1];
            seg_len[i] = seg_len[i+1];
            seg_taken[i] = seg_taken[i+1];
            seg_owner[i] = seg_owner[i+1];
            seg_word[i] = seg_word[i+1];
        end
        seg_n--;
    endfunction

    function automatic seg_result_t apply_command(cmd_t c, logic [7:0] t, logic [16:0] r,
                                                  logic [31:0] w);
        seg_result_t res;
        int unsigned need;
        int hit;
        int k;
        res = '{ST_OK, '0, '0, '0, '0};
        hit = -1;
        case (c)
            CMD_ALLOC:
            begin
                need = (r == 0) ? 1 : r;
                if (granule != 0)
                    need = ((need + granule - 1) / granule) * granule;
                if (owner_of(t) >= 0)
                    res.st = ST_EXISTS;
                else
                begin
                    for (int i = 0; i < seg_n && hit < 0; i++)
                        if (!seg_taken[i] && seg_len[i] >= need)
                            hit = i;
                    if (hit < 0)
                        res.st = ST_NOFIT;
                    else if (seg_len[hit] != need && seg_n >= SLOTS)
                        res.st = ST_FULL;
                    else
                    begin
                        if (seg_len[hit] != need)
                        begin
                            for (int i = seg_n; i > hit + 1; i--)
                            begin
                                seg_base[i] = seg_base[i-1];
                                seg_len[i] = seg_len[i-1];
                                seg_taken[i] = seg_taken[i-1];
                                seg_owner[i] = seg_owner[i-1];
                                seg_word[i] = seg_word[i-1];
                            end
                            seg_base[hit+1] = seg_base[hit] + need;
                            seg_len[hit+1] = seg_len[hit] - need;
                            seg_taken[hit+1] = 0;
                            seg_owner[hit+1] = '0;
                            seg_word[hit+1] = '0;
                            seg_len[hit] = need;
                            seg_n++;
                        end
                        seg_taken[hit] = 1;
                        seg_owner[hit] = t;
                        seg_word[hit] = w;
                        used_units += need;
                        res.off = seg_base[hit];
                        res.size = seg_len[hit];
                    end
                end
            end
            CMD_FREE, CMD_LOOKUP:
            begin
                k = owner_of(t);
                if (k < 0)
                    res.st = ST_UNKNOWN;
                else
                begin
                    res.off = seg_base[k];
                    res.size = seg_len[k];
                    res.word = seg_word[k];
                    if (c == CMD_FREE)
                    begin
                        used_units -= seg_len[k];
                        seg_taken[k] = 0;
                        seg_owner[k] = '0;
                        seg_word[k] = '0;
                        if (k + 1 < seg_n && !seg_taken[k+1])
                        begin
                            seg_len[k] += seg_len[k+1];
                            drop_segment(k + 1);
                        end
                        if (k > 0 && !seg_taken[k-1])
                        begin
                            seg_len[k-1] += seg_len[k];
                            drop_segment(k);
                        end
                    end
                end
            end
            default:
                res.st = ST_UNKNOWN;
        endcase
        res.used = used_units;
        return res;
    endfunction

    function automatic int tx_idle_pct();
        return (accepted < 470) ? 16 : (accepted < 940) ? 61 : 0;
    endfunction

    function automatic int rx_idle_pct();
        return (accepted < 470) ? 61 : (accepted < 940) ? 16 : 0;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic issue(cmd_t c, logic [7:0] t, logic [16:0] r, logic [31:0] w,
                         bit typed, seg_result_t typed_res);
        seg_result_t p;
        while ($urandom_range(99) < tx_idle_pct())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        command = c;
        tag = t;
        request_size = r;
        user_word = w;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        p = apply_command(c, t, r, w);
        pending_results.push_back(typed ? typed_res : p);
        accepted++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_TOTAL_SPACE)
        begin
            space_units = (value == 0) ? 1 : (value > 65536) ? 65536 : value;
            clear_segments();
        end
        else
            granule = value[12:0];
    endtask

    task automatic run_phase(logic [16:0] total, logic [16:0] align, int n,
                             int unsigned req_max, bit hold);
        int unsigned pick;
        cmd_t c;
        logic [16:0] r;
        drain();
        write_reg(1'(REG_TOTAL_SPACE), total);
        write_reg(1'(REG_ALIGN_UNIT), align);
        if (hold)
            hold_req++;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            c = (pick < 45) ? CMD_ALLOC : (pick < 75) ? CMD_FREE :
                (pick < 95) ? CMD_LOOKUP : CMD_NONE;
            r = ($urandom_range(3) != 0) ? 17'($urandom_range(req_max / 8))
                                         : 17'($urandom_range(req_max));
            issue(c, ($urandom_range(99) < 85) ? 8'($urandom_range(15))
                                               : 8'($urandom_range(255)),
                  r, $urandom(), 1'b0, '{ST_OK, '0, '0, '0, '0});
        end
    endtask

    initial
    begin
        int hold_seen;
        hold_seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(99) >= rx_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        seg_result_t e;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status);
                    errors++;
                end
                if (seg_offset_out !== e.off)
                begin
                    $error("seg_offset_out exp %0d got %0d", e.off, seg_offset_out);
                    errors++;
                end
                if (seg_size_out !== e.size)
                begin
                    $error("seg_size_out exp %0d got %0d", e.size, seg_size_out);
                    errors++;
                end
                if (user_word_out !== e.word)
                begin
                    $error("user_word_out exp %h got %h", e.word, user_word_out);
                    errors++;
                end
                if (used_space_out !== e.used)
                begin
                    $error("used_space_out exp %0d got %0d", e.used, used_space_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            stall = 0;
        else
            stall++;
        if (stall >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_NONE;
        tag = '0;
        request_size = '0;
        user_word = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        accepted = 0;
        hold_req = 0;
        space_units = 65536;
        granule = 0;
        clear_segments();

        rows[0]  = '{CMD_LOOKUP, 8'd5, 17'd0, 32'h0,
                     '{ST_UNKNOWN, 16'd0, 17'd0, 32'h0, 17'd0}};
        rows[1]  = '{CMD_FREE, 8'd5, 17'd0, 32'h0,
                     '{ST_UNKNOWN, 16'd0, 17'd0, 32'h0, 17'd0}};
        rows[2]  = '{CMD_NONE, 8'd0, 17'd1, 32'h0,
                     '{ST_UNKNOWN, 16'd0, 17'd0, 32'h0, 17'd0}};
        rows[3]  = '{CMD_ALLOC, 8'd0, 17'd0, 32'h0,
                     '{ST_OK, 16'd0, 17'd1, 32'h0, 17'd1}};
        rows[4]  = '{CMD_ALLOC, 8'd0, 17'd4, 32'h1,
                     '{ST_EXISTS, 16'd0, 17'd0, 32'h0, 17'd1}};
        rows[5]  = '{CMD_ALLOC, 8'd255, 17'd65536, 32'h0,
                     '{ST_NOFIT, 16'd0, 17'd0, 32'h0, 17'd1}};
        rows[6]  = '{CMD_ALLOC, 8'd255, 17'd65535, 32'hFFFFFFFF,
                     '{ST_OK, 16'd1, 17'd65535, 32'h0, 17'd65536}};
        rows[7]  = '{CMD_LOOKUP, 8'd255, 17'd0, 32'h0,
                     '{ST_OK, 16'd1, 17'd65535, 32'hFFFFFFFF, 17'd65536}};
        rows[8]  = '{CMD_FREE, 8'd0, 17'd0, 32'h0,
                     '{ST_OK, 16'd0, 17'd1, 32'h0, 17'd65535}};
        rows[9]  = '{CMD_FREE, 8'd255, 17'd0, 32'h0,
                     '{ST_OK, 16'd1, 17'd65535, 32'hFFFFFFFF, 17'd0}};
        rows[10] = '{CMD_ALLOC, 8'd1, 17'd65536, 32'h12345678,
                     '{ST_OK, 16'd0, 17'd65536, 32'h0, 17'd65536}};
        rows[11] = '{CMD_LOOKUP, 8'd1, 17'd0, 32'h0,
                     '{ST_OK, 16'd0, 17'd65536, 32'h12345678, 17'd65536}};
        rows[12] = '{CMD_ALLOC, 8'd2, 17'd1, 32'h0,
                     '{ST_NOFIT, 16'd0, 17'd0, 32'h0, 17'd65536}};
        rows[13] = '{CMD_FREE, 8'd1, 17'd0, 32'h0,
                     '{ST_OK, 16'd0, 17'd65536, 32'h12345678, 17'd0}};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            issue(rows[i].cmd, rows[i].tag, rows[i].req, rows[i].word, 1'b1, rows[i].res);

        // fill the table to its limit, then split refused, exact fit accepted
        for (int i = 0; i < SLOTS - 1; i++)
            issue(CMD_ALLOC, 8'(100 + i), 17'd1, $urandom(), 1'b0, rows[0].res);
        issue(CMD_ALLOC, 8'd200, 17'd1, 32'h0, 1'b0, rows[0].res);
        issue(CMD_ALLOC, 8'd201, 17'd65505, 32'hA5A5A5A5, 1'b0, rows[0].res);
        for (int i = 0; i < SLOTS - 1; i += 2)
            issue(CMD_FREE, 8'(100 + i), 17'd0, 32'h0, 1'b0, rows[0].res);
        issue(CMD_LOOKUP, 8'd201, 17'd0, 32'h0, 1'b0, rows[0].res);

        run_phase(17'h1FFFF, 17'd8191, 100, 131071, 1'b0);
        run_phase(17'd0, 17'd0, 60, 3, 1'b1);
        run_phase(17'd100, 17'd0, 200, 40, 1'b0);
        run_phase(17'd256, 17'd7, 200, 64, 1'b0);
        run_phase(17'd64, 17'd1, 200, 80, 1'b1);
        run_phase(17'd4096, 17'd4096, 100, 8192, 1'b0);
        run_phase(17'd1000, 17'd13, 200, 300, 1'b0);
        run_phase(17'd65536, 17'd0, 280, 131071, 1'b0);

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
